FILE: src/chromaticity_to_rgb_core_assert.svh
// Assertion macros shared by the checker of the chromaticity-to-RGB core.
// Depends on nothing; included by the checker file.
`ifndef CHROMATICITY_TO_RGB_CORE_ASSERT_SVH
`define CHROMATICITY_TO_RGB_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRGB_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("crgb: implication violated");

// Implication with a delay given by the argument n.
`define CRGB_ASSERT_DLY(label, ck, rn, ante, n, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##n (cons)) \
        else $error("crgb: delayed implication violated");

`endif

FILE: src/crgb_pkg.sv
// Shared types and constants of the chromaticity-to-RGB core.
// Holds the transfer structs, field widths and the primaries behind the matrix.
// Depends on nothing.
package crgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CHROMA_W      = 16;
    localparam int LUM_W         = 24;
    localparam int CH_W          = 24;
    localparam int NCH           = 3;
    localparam int CODE_W        = CHROMA_W + 2;
    localparam int LO_W          = 24;
    localparam int NUM_W         = LUM_W + CODE_W + 4;
    localparam int REM_W         = CH_W + CHROMA_W;
    localparam int FRONT_STAGES  = 5;
    localparam int LATENCY       = FRONT_STAGES + CH_W + 2;

    localparam logic signed [CODE_W-1:0] UNIT_CODE = CODE_W'(1 << CHROMA_W);

    // Primaries and white point in units of 1/10000.
    localparam longint PXR  = 6400;
    localparam longint PYR  = 3300;
    localparam longint PXG  = 2900;
    localparam longint PYG  = 6000;
    localparam longint PXB  = 1500;
    localparam longint PYB  = 600;
    localparam longint PXW  = 3333;
    localparam longint PYW  = 3333;
    localparam longint TEN4 = 10000;

    localparam longint MAT_DEN [NCH] = '{
        PXW * (PYG - PYB) - PYW * (PXG - PXB) + PXG * PYB - PXB * PYG,
        PXW * (PYB - PYR) - PYW * (PXB - PXR) - PXR * PYB + PXB * PYR,
        PXW * (PYR - PYG) - PYW * (PXR - PXG) + PXR * PYG - PXG * PYR
    };

    // Row-major numerators of the XYZ-to-RGB matrix, in units of 1e-8.
    localparam longint MAT_NUM [NCH*NCH] = '{
        (PYG - PYB) * TEN4 - PXB * PYG + PYB * PXG,
        (PXB - PXG) * TEN4 - PXB * PYG + PXG * PYB,
        PXG * PYB - PXB * PYG,
        (PYB - PYR) * TEN4 - PYB * PXR + PYR * PXB,
        (PXR - PXB) * TEN4 - PXR * PYB + PXB * PYR,
        PXB * PYR - PXR * PYB,
        (PYR - PYG) * TEN4 - PYR * PXG + PYG * PXR,
        (PXG - PXR) * TEN4 - PXG * PYR + PXR * PYG,
        PXR * PYG - PXG * PYR
    };

    typedef struct packed {
        logic [CHROMA_W-1:0] chroma_x;
        logic [CHROMA_W-1:0] chroma_y;
        logic [LUM_W-1:0]    luminance;
    } crgb_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            bad_chroma;
    } crgb_out_t;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic bad;
    } crgb_ctl_t;

endpackage

FILE: src/crgb_div.sv
// Pipelined restoring divider for the three color channels, one quotient bit per stage.
// Flags quotients that do not fit the channel width. Depends on crgb_pkg.
module crgb_div
    import crgb_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  crgb_ctl_t                      ctl_in,
    input  logic [CHROMA_W-1:0]            den,
    input  logic [NCH-1:0][NUM_W-1:0]      num,
    output crgb_ctl_t                      ctl_out,
    output logic [NCH-1:0][CH_W-1:0]       quot,
    output logic [NCH-1:0]                 ovf
);

    localparam int STEPS = CH_W;

    crgb_ctl_t                  ctl_reg  [STEPS+1];
    logic [CHROMA_W-1:0]        den_reg  [STEPS];
    logic [NCH-1:0][REM_W-1:0]  rem_reg  [STEPS];
    logic [NCH-1:0][CH_W-1:0]   quot_reg [STEPS+1];
    logic [NCH-1:0]             ovf_reg  [STEPS+1];
    logic [NUM_W-1:0]           limit_next;

    // A quotient fits the channel only when the numerator is below den * 2^CH_W.
    assign limit_next = {{(NUM_W - REM_W){1'b0}}, den, {CH_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int c = 0; c < NCH; c++)
        begin
            ovf_reg[0][c]  <= (num[c] >= limit_next);
            rem_reg[0][c]  <= num[c][REM_W-1:0];
            quot_reg[0][c] <= '0;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int BIT = STEPS - 1 - j;

        logic [REM_W-1:0]           dsh_next;
        logic [NCH-1:0]             take_next;
        logic [NCH-1:0][REM_W-1:0]  rem_next;

        assign dsh_next = REM_W'(den_reg[j]) << BIT;

        always_comb
        begin
            for (int c = 0; c < NCH; c++)
            begin
                take_next[c] = (rem_reg[j][c] >= dsh_next);
                rem_next[c]  = take_next[c] ? (rem_reg[j][c] - dsh_next) : rem_reg[j][c];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j+1] <= '0;
            end
            else
            begin
                ctl_reg[j+1] <= ctl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            ovf_reg[j+1] <= ovf_reg[j];
            for (int c = 0; c < NCH; c++)
            begin
                quot_reg[j+1][c] <= {quot_reg[j][c][CH_W-2:0], take_next[c]};
            end
        end

        if (j < STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                den_reg[j+1] <= den_reg[j];
                rem_reg[j+1] <= rem_next;
            end
        end
    end

    assign ctl_out = ctl_reg[STEPS];
    assign quot    = quot_reg[STEPS];
    assign ovf     = ovf_reg[STEPS];

endmodule

FILE: src/chromaticity_to_rgb_core.sv
// Converts CIE xyY colors to clamped linear RGB through a fixed XYZ-to-RGB matrix.
// Top level; depends on crgb_pkg and crgb_div.
//
// Usage: drive xyy and raise start; the transfer is taken at a rising edge where
// start is high and busy is low. busy is high during reset and in the first cycle
// after reset is released, so from then on one color can be taken every clock.
// Each result shows on rgb for exactly one cycle with done high, in input
// order. The receiver cannot hold results off, so the pipeline never stalls.
// Each item passes five front stages (codes, matrix products, row sums, the
// luminance product, its assembly), one range-check stage, the 24 one-bit
// stages of the divider and the output register. Throughput is one item per
// clock.
// A y of zero gives bad_chroma high and zero channels. Negative channels read
// zero and channels above the Q8.16 range saturate.
// Reset (asynchronous, active low) empties the pipeline; items in flight are
// dropped and no done pulse follows for them.
module chromaticity_to_rgb_core
    import crgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  crgb_in_t  xyy,
    output logic      done,
    output crgb_out_t rgb
);

    localparam int COEF_W = FRAC_BITS + 3;
    localparam int PROD_W = COEF_W + CODE_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int WIDE_W = MAG_W + LUM_W;

    logic signed [COEF_W-1:0] coef [NCH][NCH];

    // Coefficients rounded to nearest, ties away from zero.
    for (genvar r = 0; r < NCH; r++) begin : g_row
        for (genvar c = 0; c < NCH; c++) begin : g_col
            localparam longint Scl = MAT_NUM[r*NCH + c] * PYW * (longint'(1) << FRAC_BITS);
            localparam longint Dv  = MAT_DEN[r] * TEN4;
            localparam longint Cv  = (Scl >= 0) ? ((Scl + Dv / 2) / Dv)
                                                : -((-Scl + Dv / 2) / Dv);
            assign coef[r][c] = Cv[COEF_W-1:0];
        end
    end

    logic      busy_reg;
    logic      accept;
    crgb_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    crgb_ctl_t ctl1_next;
    crgb_ctl_t div_ctl;
    logic      done_reg;

    logic signed [CODE_W-1:0]  code1_reg [NCH];
    logic signed [CODE_W-1:0]  code1_next [NCH];
    logic [CHROMA_W-1:0]       y1_reg, y2_reg, y3_reg, y4_reg, y5_reg;
    logic [LUM_W-1:0]          lum1_reg, lum2_reg, lum3_reg;

    logic signed [PROD_W-1:0]  prod2_reg [NCH][NCH];
    logic signed [SUM_W-1:0]   sum3_reg  [NCH];
    logic [MAG_W-1:0]          mag_next  [NCH];
    logic [LUM_W+LO_W-1:0]     lo4_reg   [NCH];
    logic [LUM_W+HI_W-1:0]     hi4_reg   [NCH];
    logic [WIDE_W-1:0]         wide_next [NCH];
    logic [NCH-1:0][NUM_W-1:0] num5_reg;

    logic [NCH-1:0][CH_W-1:0]  div_quot;
    logic [NCH-1:0]            div_ovf;
    logic [NCH-1:0][CH_W-1:0]  chan_next;
    crgb_out_t                 rgb_reg;

    assign accept = start & ~busy_reg;
    assign busy   = busy_reg;

    assign ctl1_next.valid = accept;
    assign ctl1_next.bad   = (xyy.chroma_y == '0);

    assign code1_next[0] = $signed({2'b00, xyy.chroma_x});
    assign code1_next[1] = $signed({2'b00, xyy.chroma_y});
    assign code1_next[2] = UNIT_CODE - $signed({2'b00, xyy.chroma_x})
                                     - $signed({2'b00, xyy.chroma_y});

    always_comb
    begin
        for (int r = 0; r < NCH; r++)
        begin
            mag_next[r]  = (sum3_reg[r] > 0) ? sum3_reg[r][MAG_W-1:0] : '0;
            wide_next[r] = (WIDE_W'(hi4_reg[r]) << LO_W) + WIDE_W'(lo4_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            done_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        code1_reg <= code1_next;
        y1_reg    <= xyy.chroma_y;
        lum1_reg  <= xyy.luminance;

        y2_reg    <= y1_reg;
        lum2_reg  <= lum1_reg;
        for (int r = 0; r < NCH; r++)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                prod2_reg[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(code1_reg[c]);
            end
        end

        y3_reg   <= y2_reg;
        lum3_reg <= lum2_reg;
        for (int r = 0; r < NCH; r++)
        begin
            sum3_reg[r] <= SUM_W'(prod2_reg[r][0]) + SUM_W'(prod2_reg[r][1])
                         + SUM_W'(prod2_reg[r][2]);
        end

        // The luminance product is split so that no multiplier exceeds 24 x 24.
        y4_reg <= y3_reg;
        for (int r = 0; r < NCH; r++)
        begin
            lo4_reg[r] <= (LUM_W+LO_W)'(lum3_reg) * (LUM_W+LO_W)'(mag_next[r][LO_W-1:0]);
            hi4_reg[r] <= (LUM_W+HI_W)'(lum3_reg) * (LUM_W+HI_W)'(mag_next[r][MAG_W-1:LO_W]);
        end

        // Dropping the coefficient fraction bits leaves a division by y alone.
        y5_reg <= y4_reg;
        for (int r = 0; r < NCH; r++)
        begin
            num5_reg[r] <= wide_next[r][WIDE_W-1:FRAC_BITS];
        end
    end

    crgb_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl5_reg),
        .den     (y5_reg),
        .num     (num5_reg),
        .ctl_out (div_ctl),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    always_comb
    begin
        for (int r = 0; r < NCH; r++)
        begin
            if (div_ctl.bad)
            begin
                chan_next[r] = '0;
            end
            else if (div_ovf[r])
            begin
                chan_next[r] = '1;
            end
            else
            begin
                chan_next[r] = div_quot[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg.red        <= chan_next[0];
        rgb_reg.green      <= chan_next[1];
        rgb_reg.blue       <= chan_next[2];
        rgb_reg.bad_chroma <= div_ctl.bad;
    end

    assign done = done_reg;
    assign rgb  = rgb_reg;

endmodule

FILE: src/crgb_checker.sv
// Port-level checker for the chromaticity-to-RGB core, bound to the top level.
// Depends on crgb_pkg and the assertion macro header.
`include "chromaticity_to_rgb_core_assert.svh"

module crgb_checker
    import crgb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input crgb_in_t  xyy,
    input logic      done,
    input crgb_out_t rgb
);

    logic xfer_in;
    logic y_zero;
    logic lum_zero;
    logic rgb_black;

    assign xfer_in   = start && !busy;
    assign y_zero    = (xyy.chroma_y == '0);
    assign lum_zero  = (xyy.luminance == '0);
    assign rgb_black = (rgb.red == '0) && (rgb.green == '0) && (rgb.blue == '0);

    // Every transfer in gives exactly one result a fixed time later.
    `CRGB_ASSERT_DLY(a_result_follows, clk, rst_n, xfer_in, LATENCY, done)
    `CRGB_ASSERT_IMP(a_no_spurious_result, clk, rst_n, done, $past(xfer_in, LATENCY))
    `CRGB_ASSERT_IMP(a_bad_flag, clk, rst_n, done, (rgb.bad_chroma == $past(y_zero, LATENCY)))
    `CRGB_ASSERT_IMP(a_dark_is_black, clk, rst_n, done && $past(lum_zero, LATENCY), rgb_black)

endmodule

bind chromaticity_to_rgb_core crgb_checker u_crgb_checker (.*);
